FILE: sv/ptr_pkg.sv
// ----------------------------------------------------------------------------
// ptr_pkg
// Shared types and constants for the poker randomness test block.
// ----------------------------------------------------------------------------
`default_nettype none

package ptr_pkg;

  localparam int NUM_VALUES  = 16;   // distinct nibble values
  localparam int IDX_W       = 4;    // nibble / counter index width
  localparam int BOUND_W     = 20;
  localparam int STAT_W      = 41;
  localparam int SEQ_W       = 32;
  localparam int CFG_IDX_W   = 1;

  // 5000 * 5000: offset of 16*S relative to X*5000
  localparam longint STAT_OFFSET = 64'd25000000;

  // 1.03 * 5000 and 57.4 * 5000
  localparam logic [BOUND_W-1:0] LOW_BOUND_RST  = 20'd5150;
  localparam logic [BOUND_W-1:0] HIGH_BOUND_RST = 20'd287000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_BOUND  = 1'b0,
    REG_HIGH_BOUND = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_ACC,
    ST_DIFF,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

FILE: sv/poker_test_randomness.sv
// ----------------------------------------------------------------------------
// poker_test_randomness
// Poker test over a serial bit stream: nibble histogram, sum of squares and
// a bounded verdict on 16*S - 25000000.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one bit per transaction, MSB
//   first into nibbles; one bit per cycle while the block is collecting.
//   A transaction with in_last_bit set closes the sequence. The block then
//   raises in_stall and walks the 16 counters through one shared squarer and
//   accumulator, one counter per cycle, clearing each as it is read.
//   After the last bit the block squares the 16 counters, flushes the
//   accumulator, subtracts the statistic offset and compares with the bounds;
//   in_stall stays high through these steps and then drops.
//   Output channel (out_valid / out_stall) holds one result in a register.
//   Bits of the next sequence may flow while a result waits; if the next
//   evaluation finishes before the old result is taken, the block holds in
//   its final step with in_stall high until out_stall drops.
//   cfg_we writes low_bound (index 0) or high_bound (index 1).
//   Reset (rst_n low, synchronous) clears the counters, nibble assembly and
//   sequence number and restores the default bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module poker_test_randomness
  import ptr_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_bit_value,
  input  wire logic                 in_last_bit,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_is_random,
  output logic signed [STAT_W-1:0]  out_statistic,
  output logic [SEQ_W-1:0]          out_sequence_number,

  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BOUND_W-1:0]   cfg_wdata
);

  localparam int PROD_W = 2 * COUNT_WIDTH;
  localparam int ACC_W  = PROD_W + IDX_W;
  localparam int D_W    = (ACC_W + 5 > STAT_W + 1) ? ACC_W + 5 : STAT_W + 1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic signed [D_W-1:0]  OFFSET_D  = D_W'(STAT_OFFSET);
  localparam logic signed [D_W-1:0]  STAT_MAX  = D_W'((64'd1 << (STAT_W - 1)) - 64'd1);

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r;
  logic [2:0]              partial_r;
  logic [1:0]              bit_pos_r;
  logic [COUNT_WIDTH-1:0]  cnt_r [NUM_VALUES];
  logic [SEQ_W-1:0]        seq_r;
  logic [BOUND_W-1:0]      low_bound_r, high_bound_r;

  logic [PROD_W-1:0]       sq_r;
  logic [ACC_W-1:0]        acc_r;
  logic signed [D_W-1:0]   d_r;

  logic                    out_valid_r;
  logic                    is_random_r;
  logic [STAT_W-1:0]       stat_r;
  logic [SEQ_W-1:0]        seq_out_r;

  // control from the sequencer
  logic                    in_take;
  logic                    sum_en, acc_en, diff_en, out_load;

  logic [IDX_W-1:0]        nib;
  logic [IDX_W-1:0]        rd_addr;
  logic [COUNT_WIDTH-1:0]  rd_data;
  logic [PROD_W-1:0]       prod;
  logic [D_W-1:0]          s16;
  logic signed [D_W-1:0]   d_nxt;
  logic signed [D_W-1:0]   low_ext, high_ext;

  // --- next state -----------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && in_last_bit) state_nxt = ST_SUM;
      ST_SUM:  if (idx_r == IDX_W'(NUM_VALUES - 1)) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --- sequencer outputs ----------------------------------------------------
  always_comb begin
    in_stall = 1'b1;
    sum_en   = 1'b0;
    acc_en   = 1'b0;
    diff_en  = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_SUM:  sum_en   = 1'b1;
      ST_ACC:  acc_en   = 1'b1;
      ST_DIFF: diff_en  = 1'b1;
      ST_OUT:  out_load = !out_valid_r || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign in_take = in_valid && !in_stall;

  // --- datapath -------------------------------------------------------------
  assign nib     = {partial_r, in_bit_value};
  assign rd_addr = sum_en ? idx_r : nib;
  assign rd_data = cnt_r[rd_addr];
  assign prod    = PROD_W'(rd_data) * PROD_W'(rd_data);

  assign s16      = D_W'(acc_r) << 4;
  assign d_nxt    = $signed(s16) - OFFSET_D;
  assign low_ext  = $signed(D_W'(low_bound_r));
  assign high_ext = $signed(D_W'(high_bound_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      partial_r    <= '0;
      bit_pos_r    <= '0;
      seq_r        <= '0;
      low_bound_r  <= LOW_BOUND_RST;
      high_bound_r <= HIGH_BOUND_RST;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NUM_VALUES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          REG_LOW_BOUND:  low_bound_r  <= cfg_wdata;
          REG_HIGH_BOUND: high_bound_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (in_take) begin
        if (bit_pos_r == 2'd3 && rd_data != COUNT_MAX) begin
          cnt_r[rd_addr] <= rd_data + COUNT_WIDTH'(1);
        end
        // trailing partial nibble is dropped
        if (bit_pos_r == 2'd3 || in_last_bit) begin
          partial_r <= '0;
          bit_pos_r <= '0;
        end else begin
          partial_r <= {partial_r[1:0], in_bit_value};
          bit_pos_r <= bit_pos_r + 2'd1;
        end
        idx_r <= '0;
      end

      // each counter is cleared as it is squared
      if (sum_en) begin
        cnt_r[rd_addr] <= '0;
        idx_r          <= idx_r + IDX_W'(1);
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        seq_r       <= seq_r + SEQ_W'(1);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      sq_r  <= '0;
      acc_r <= '0;
    end
    if (sum_en) begin
      sq_r  <= prod;
      acc_r <= acc_r + ACC_W'(sq_r);
    end
    if (acc_en) acc_r <= acc_r + ACC_W'(sq_r);
    if (diff_en) d_r <= d_nxt;
    if (out_load) begin
      is_random_r <= (d_r > low_ext) && (d_r < high_ext);
      stat_r      <= (d_r > STAT_MAX) ? STAT_MAX[STAT_W-1:0] : d_r[STAT_W-1:0];
      seq_out_r   <= seq_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_is_random       = is_random_r;
  assign out_statistic       = $signed(stat_r);
  assign out_sequence_number = seq_out_r;

  // --- assertions -----------------------------------------------------------
  a_last_starts_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_bit) |=> (state_r == ST_SUM))
    else $error("last bit did not start the squaring pass");

  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result appeared outside the final step");

  a_idx_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM && idx_r != IDX_W'(NUM_VALUES - 1)) |=>
      (state_r == ST_SUM && idx_r == $past(idx_r) + IDX_W'(1)))
    else $error("counter walk skipped an entry");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(seq_out_r))
    else $error("pending result lost or overwritten");

endmodule

`default_nettype wire

FILE: tb/tb_poker_test_randomness.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_poker_test_randomness
// Self-checking bench for the serial poker test: bit streams go in, one
// verdict per closed sequence comes out and is checked against a histogram
// and sum-of-squares predictor kept alongside the block.
// ----------------------------------------------------------------------------

typedef struct {
  logic                              is_random;
  logic signed [ptr_pkg::STAT_W-1:0] statistic;
  logic [ptr_pkg::SEQ_W-1:0]         seq_no;
} poker_verdict_t;

class poker_scoreboard;
  int unsigned                 tally_max;
  logic [ptr_pkg::BOUND_W-1:0] low_lim;
  logic [ptr_pkg::BOUND_W-1:0] high_lim;
  logic [2:0]                  nib_bits;
  logic [1:0]                  nib_pos;
  int unsigned                 tally [ptr_pkg::NUM_VALUES];
  logic [ptr_pkg::SEQ_W-1:0]   seq_ctr;
  poker_verdict_t              pending [$];
  int unsigned                 errors;
  int unsigned                 checked;

  function new(int count_w);
    tally_max = (32'd1 << count_w) - 1;
    low_lim   = ptr_pkg::LOW_BOUND_RST;
    high_lim  = ptr_pkg::HIGH_BOUND_RST;
    seq_ctr   = '0;
    errors    = 0;
    checked   = 0;
    clear_counts();
  endfunction

  function void clear_counts();
    nib_bits = '0;
    nib_pos  = '0;
    foreach (tally[i]) tally[i] = 0;
  endfunction

  function void set_bound(ptr_pkg::reg_idx_t idx, logic [ptr_pkg::BOUND_W-1:0] val);
    case (idx)
      ptr_pkg::REG_LOW_BOUND:  low_lim  = val;
      ptr_pkg::REG_HIGH_BOUND: high_lim = val;
      default: ;
    endcase
  endfunction

  // One accepted input transaction; the last bit is absorbed before evaluation.
  function void note_bit(bit b, bit last);
    logic [3:0]      nib;
    longint unsigned cnt;
    longint unsigned sum_sq;
    longint          stat;
    longint          stat_cap;
    poker_verdict_t  v;
    if (nib_pos == 2'd3) begin
      nib = {nib_bits, b};
      if (tally[nib] < tally_max) tally[nib]++;
      nib_bits = '0;
      nib_pos  = '0;
    end else begin
      nib_bits = {nib_bits[1:0], b};
      nib_pos++;
    end
    if (!last) return;
    sum_sq = 0;
    foreach (tally[i]) begin
      cnt = tally[i];
      sum_sq += cnt * cnt;
    end
    stat        = longint'(sum_sq * 16) - ptr_pkg::STAT_OFFSET;
    v.is_random = (stat > longint'(low_lim)) && (stat < longint'(high_lim));
    // compare at full precision, show a clipped value
    stat_cap = (64'sd1 <<< (ptr_pkg::STAT_W - 1)) - 1;
    if (stat > stat_cap) stat = stat_cap;
    v.statistic = stat[ptr_pkg::STAT_W-1:0];
    v.seq_no    = seq_ctr;
    seq_ctr++;
    pending.push_back(v);
    clear_counts();
  endfunction

  task report(string msg);
    errors++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task check_result(logic r, logic signed [ptr_pkg::STAT_W-1:0] st,
                    logic [ptr_pkg::SEQ_W-1:0] sn);
    poker_verdict_t v;
    if (pending.size() == 0) begin
      report($sformatf("unexpected verdict: seq %0d stat %0d", sn, st));
      return;
    end
    v = pending.pop_front();
    checked++;
    if (sn !== v.seq_no)
      report($sformatf("sequence_number got %0d exp %0d", sn, v.seq_no));
    if (st !== v.statistic)
      report($sformatf("seq %0d statistic got %0d exp %0d", v.seq_no, st, v.statistic));
    if (r !== v.is_random)
      report($sformatf("seq %0d is_random got %b exp %b", v.seq_no, r, v.is_random));
  endtask

  task flush_check();
    if (pending.size() != 0)
      report($sformatf("%0d verdicts never arrived, oldest seq %0d",
                       pending.size(), pending[0].seq_no));
  endtask
endclass

module tb_poker_test_randomness;
  import ptr_pkg::*;

  localparam int COUNT_W      = 16;
  localparam int EVAL_LATENCY = 19;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RANDOM_ITEMS = 280;

  typedef enum int {FILL_UNIFORM, FILL_REPEAT, FILL_SPARSE, FILL_CONST} fill_t;

  logic                     clk          = 1'b0;
  logic                     rst_n        = 1'b0;
  logic                     in_valid     = 1'b0;
  logic                     in_bit_value = 1'b0;
  logic                     in_last_bit  = 1'b0;
  logic                     in_stall;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic                     out_is_random;
  logic signed [STAT_W-1:0] out_statistic;
  logic [SEQ_W-1:0]         out_sequence_number;
  logic                     cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index    = '0;
  logic [BOUND_W-1:0]       cfg_wdata    = '0;

  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  int unsigned hold_reqs    = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;
  int unsigned cycle_count  = 0;
  int unsigned bits_sent    = 0;
  int unsigned longest_seq  = 0;
  int unsigned bound_writes = 0;

  poker_scoreboard sb;

  poker_test_randomness #(.COUNT_WIDTH(COUNT_W)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_bit_value        (in_bit_value),
    .in_last_bit         (in_last_bit),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_is_random       (out_is_random),
    .out_statistic       (out_statistic),
    .out_sequence_number (out_sequence_number),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_is_random, out_statistic, out_sequence_number);
  end

  task automatic send_bit(input bit b, input bit last);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_bit_value <= b;
    in_last_bit  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_bit(b, last);
    bits_sent++;
  endtask

  task automatic send_sequence(input int unsigned len, input fill_t fill,
                               input logic [3:0] pat);
    bit b;
    for (int unsigned i = 0; i < len; i++) begin
      case (fill)
        FILL_UNIFORM: b = $urandom_range(1);
        FILL_REPEAT:  b = pat[3 - (i % 4)];
        FILL_SPARSE:  b = ($urandom_range(7) == 0);
        default:      b = pat[0];
      endcase
      send_bit(b, i == len - 1);
    end
    if (len > longest_seq) longest_seq = len;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_bound(input reg_idx_t idx, input logic [BOUND_W-1:0] val);
    wait_drained();
    // an open sequence never leaves work behind, but give the datapath time
    repeat (EVAL_LATENCY + 6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_bound(idx, val);
    bound_writes++;
  endtask

  task automatic random_phase(input int unsigned sender_idle,
                              input int unsigned receiver_stall, input bit squeeze);
    int unsigned start_bits;
    int unsigned len;
    int unsigned pick;
    bit          paused;
    fill_t       fill;
    stall_pct <= receiver_stall;
    write_bound(REG_LOW_BOUND, BOUND_W'($urandom_range(1000000)));
    write_bound(REG_HIGH_BOUND, BOUND_W'($urandom_range(1000000)));
    if (squeeze) hold_reqs <= hold_reqs + 1;
    start_bits = bits_sent;
    paused     = 1'b0;
    while (bits_sent - start_bits < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      len  = (pick < 80) ? $urandom_range(20, 1) :
             (pick < 98) ? $urandom_range(80, 21) : $urandom_range(300, 81);
      pick = $urandom_range(99);
      fill = (pick < 50) ? FILL_UNIFORM : (pick < 75) ? FILL_REPEAT :
             (pick < 90) ? FILL_SPARSE : FILL_CONST;
      gap_pct = ($urandom_range(5) == 0) ? 0 : sender_idle;
      send_sequence(len, fill, 4'($urandom_range(15)));
      if (!paused && bits_sent - start_bits >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end
  endtask

  initial begin
    sb = new(COUNT_W);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short directed sequences under the reset bounds
    gap_pct = 0;
    send_bit(1'b0, 1'b1);
    send_bit(1'b1, 1'b1);
    send_sequence(4, FILL_REPEAT, 4'hF);
    send_sequence(4, FILL_REPEAT, 4'h0);
    send_sequence(7, FILL_REPEAT, 4'hA);   // trailing three bits dropped
    send_sequence(8, FILL_REPEAT, 4'h5);

    random_phase(0, 0, 1'b1);
    random_phase(84, 0, 1'b0);
    random_phase(0, 84, 1'b1);
    random_phase(37, 37, 1'b0);

    wait_drained();
    repeat (EVAL_LATENCY + 20) @(posedge clk);
    sb.flush_check();
    $display("Checked %0d verdicts from %0d bits (longest sequence %0d bits), %0d bound writes.",
             sb.checked, bits_sent, longest_seq, bound_writes);
    $display("Run mixed short and long sequences, dropped partial nibbles, random bounds and back-pressure.");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ptr_pkg.sv
sv/poker_test_randomness.sv
tb/tb_poker_test_randomness.sv
